@@ design/est_pkg.sv @@
// ----------------------------------------------------------------------------
// Engine speed tachometer package
// Shared widths, constants, sequencer states and divider control type.
// ----------------------------------------------------------------------------
`default_nettype none

package est_pkg;

    localparam int TIME_W  = 32;                    // timestamp width
    localparam int COUNT_W = 8;                     // pulse counter width
    localparam int RPM_W   = 16;                    // result width
    localparam int SPR_W   = 4;                     // sparks per rev register
    localparam int QUOT_W  = 26;                    // 60000000 fits in 26 bits
    localparam int PROD_W  = QUOT_W + COUNT_W;      // quotient times count
    localparam int LOW_W   = RPM_W + SPR_W;         // product bits below clamp
    localparam int PAD_W   = QUOT_W - LOW_W;        // left-align pad for pass 2
    localparam int STEP_W  = $clog2(QUOT_W + 1);    // divider step counter

    localparam logic [QUOT_W-1:0] TICKS_PER_MIN = QUOT_W'(60000000);
    localparam logic [RPM_W-1:0]  RPM_MAX       = '1;
    localparam logic [SPR_W-1:0]  SPR_RESET     = SPR_W'(2);

    localparam logic [STEP_W-1:0] STEPS_PASS1 = STEP_W'(QUOT_W);
    localparam logic [STEP_W-1:0] STEPS_PASS2 = STEP_W'(LOW_W);

    localparam logic OP_PULSE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV1_GO,
        S_DIV1_WAIT,
        S_MUL,
        S_DIV2_GO,
        S_DIV2_WAIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } t_div_ctrl;

endpackage

`default_nettype wire

@@ design/est_div.sv @@
// ----------------------------------------------------------------------------
// Engine speed tachometer iterative divider
// Restoring divider, one quotient bit per cycle, run for a chosen step count.
// The dividend must be left-aligned to the step count.
// ----------------------------------------------------------------------------
`default_nettype none

module est_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire est_pkg::t_div_ctrl         i_ctrl,
    input  wire logic [est_pkg::QUOT_W-1:0] i_dividend,
    input  wire logic [est_pkg::TIME_W-1:0] i_divisor,
    output logic      [est_pkg::QUOT_W-1:0] o_quotient,
    output logic                            o_done
);
    import est_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [QUOT_W-1:0] r_quo;
    logic [TIME_W-1:0] r_rem;
    logic [TIME_W-1:0] r_dvs;

    logic [TIME_W:0]   w_shift;
    logic [TIME_W:0]   w_diff;
    logic              w_fits;
    logic [TIME_W-1:0] n_rem;

    assign w_shift = {r_rem, r_quo[QUOT_W-1]};
    assign w_diff  = w_shift - {1'b0, r_dvs};
    assign w_fits  = (w_shift >= {1'b0, r_dvs});

    always_comb begin
        if (w_fits) begin
            n_rem = w_diff[TIME_W-1:0];
        end else begin
            n_rem = w_shift[TIME_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_ctrl.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - STEP_W'(1);
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[QUOT_W-2:0], w_fits};
            r_rem <= n_rem;
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

`default_nettype wire

@@ design/engine_speed_tachometer_top.sv @@
// ----------------------------------------------------------------------------
// Engine speed tachometer
// Flow: a pulse is counted, and a read with no pulse seen or with a zero
// interval registers its result directly on acceptance. Other reads run 26
// divider steps for 60000000/dt, a multiply, then 20 steps for the divide by
// sparks per rev (skipped when the product clamps), plus sequencing. One
// transaction at a time; pulses one per cycle while idle, output slot free.
// Reset: synchronous active-low; sparks per rev returns to 2, state clears.
// ----------------------------------------------------------------------------
`default_nettype none

module engine_speed_tachometer_top (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [est_pkg::SPR_W-1:0]  i_cfg_wdata,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic                       i_opcode,
    input  wire logic [est_pkg::TIME_W-1:0] i_time_us,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic      [est_pkg::RPM_W-1:0]  o_rpm,
    output logic                            o_saturated
);
    import est_pkg::*;

    t_state             r_state;
    t_state             n_state;
    logic [SPR_W-1:0]   r_spr;
    logic               r_seen;
    logic [COUNT_W-1:0] r_count;
    logic [TIME_W-1:0]  r_last;
    logic [TIME_W-1:0]  r_dt;
    logic [COUNT_W-1:0] r_cnt_snap;
    logic [PROD_W-1:0]  r_prod;
    logic [RPM_W-1:0]   r_res;
    logic               r_res_sat;
    logic               r_o_valid;
    logic [RPM_W-1:0]   r_rpm;
    logic               r_sat;

    logic               w_in_ready;
    logic               w_accept;
    logic               w_read;
    logic [TIME_W-1:0]  w_dt;
    logic               w_dt_zero;
    logic [SPR_W-1:0]   w_spr_eff;
    logic               w_prod_sat;
    logic               w_slot_free;
    logic               w_load_imm;
    logic               w_load_done;
    t_div_ctrl          w_div_ctrl;
    logic [QUOT_W-1:0]  w_dividend;
    logic [TIME_W-1:0]  w_divisor;
    logic [QUOT_W-1:0]  w_quotient;
    logic               w_div_done;

    assign w_slot_free = !r_o_valid || i_ready;
    assign w_accept    = i_valid && w_in_ready;
    assign w_read      = (i_opcode == OP_READ);
    assign w_dt        = i_time_us - r_last;
    assign w_dt_zero   = (w_dt == '0);
    assign w_spr_eff   = (r_spr == '0) ? SPR_W'(1) : r_spr;
    assign w_prod_sat  = r_prod >= {{(PROD_W-LOW_W){1'b0}}, w_spr_eff, {RPM_W{1'b0}}};
    assign w_load_imm  = w_accept && w_read && (!r_seen || w_dt_zero);
    assign w_load_done = (r_state == S_DONE) && w_slot_free;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && w_read && r_seen && !w_dt_zero) begin
                    n_state = S_DIV1_GO;
                end
            end
            S_DIV1_GO:   n_state = S_DIV1_WAIT;
            S_DIV1_WAIT: begin
                if (w_div_done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL:       n_state = S_DIV2_GO;
            S_DIV2_GO: begin
                if (w_prod_sat) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_DIV2_WAIT;
                end
            end
            S_DIV2_WAIT: begin
                if (w_div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default:     n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        w_in_ready       = 1'b0;
        w_div_ctrl.start = 1'b0;
        w_div_ctrl.steps = STEPS_PASS1;
        w_dividend       = TICKS_PER_MIN;
        w_divisor        = r_dt;
        unique case (r_state)
            S_IDLE: begin
                w_in_ready = w_slot_free;
            end
            S_DIV1_GO: begin
                w_div_ctrl.start = 1'b1;
            end
            S_DIV2_GO: begin
                w_div_ctrl.start = !w_prod_sat;
                w_div_ctrl.steps = STEPS_PASS2;
                w_dividend       = {r_prod[LOW_W-1:0], {PAD_W{1'b0}}};
                w_divisor        = {{(TIME_W-SPR_W){1'b0}}, w_spr_eff};
            end
            S_DIV1_WAIT, S_MUL, S_DIV2_WAIT, S_DONE: begin
                w_in_ready = 1'b0;
            end
            default: begin
                w_in_ready = 1'b0;
            end
        endcase
    end

    est_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_div_ctrl),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_quotient (w_quotient),
        .o_done     (w_div_done)
    );

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_spr     <= SPR_RESET;
            r_seen    <= 1'b0;
            r_count   <= '0;
            r_last    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_spr <= i_cfg_wdata;
            end
            if (w_accept) begin
                if (!w_read) begin
                    r_seen <= 1'b1;
                    if (r_count != '1) begin
                        r_count <= r_count + COUNT_W'(1);
                    end
                end else if (r_seen) begin
                    // counted read: clear and take the new reference time
                    r_seen  <= 1'b0;
                    r_count <= '0;
                    r_last  <= i_time_us;
                end
            end
            if (w_load_imm || w_load_done) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (w_accept && w_read) begin
            r_dt       <= w_dt;
            r_cnt_snap <= r_count;
        end
        if (r_state == S_MUL) begin
            r_prod <= PROD_W'(w_quotient) * PROD_W'(r_cnt_snap);
        end
        if ((r_state == S_DIV2_GO) && w_prod_sat) begin
            r_res     <= RPM_MAX;
            r_res_sat <= 1'b1;
        end else if ((r_state == S_DIV2_WAIT) && w_div_done) begin
            r_res     <= w_quotient[RPM_W-1:0];
            r_res_sat <= 1'b0;
        end
        if (w_load_imm) begin
            r_rpm <= r_seen ? RPM_MAX : '0;
            r_sat <= r_seen;
        end else if (w_load_done) begin
            r_rpm <= r_res;
            r_sat <= r_res_sat;
        end
    end

    assign o_ready     = w_in_ready;
    assign o_valid     = r_o_valid;
    assign o_rpm       = r_rpm;
    assign o_saturated = r_sat;

endmodule

`default_nettype wire

@@ bench/engine_speed_tachometer_top_test.sv @@
// ----------------------------------------------------------------------------
// Engine speed tachometer testbench
// Drives pulse edges and speed reads through the valid/ready input channel.
// A local model predicts each speed result, and the results are checked in
// order against it. Random gaps and a long receiver hold-off are applied on
// both sides. The sparks-per-rev register is swept between drained phases.
// ----------------------------------------------------------------------------
`default_nettype none

module engine_speed_tachometer_top_test;
    import est_pkg::*;

    typedef struct packed {
        logic              op;
        logic [TIME_W-1:0] stamp;
    } t_tach_item;

    typedef struct packed {
        logic [RPM_W-1:0] rpm;
        logic             sat;
    } t_speed;

    localparam longint unsigned MINUTE_US     = 64'd60000000;
    localparam longint unsigned RPM_LIMIT     = 64'd65535;
    localparam int              SETTLE_CYCLES = 100;
    localparam int              PHASE_ITEMS   = 150;
    localparam int              HOLD_CYCLES   = 300;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_cfg_we    = 1'b0;
    logic [SPR_W-1:0]  i_cfg_wdata = SPR_RESET;
    logic              i_valid     = 1'b0;
    logic              i_opcode    = OP_PULSE;
    logic [TIME_W-1:0] i_time_us   = '0;
    logic              i_ready     = 1'b0;
    logic              o_ready;
    logic              o_valid;
    logic [RPM_W-1:0]  o_rpm;
    logic              o_saturated;

    engine_speed_tachometer_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_opcode    (i_opcode),
        .i_time_us   (i_time_us),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_rpm       (o_rpm),
        .o_saturated (o_saturated)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_tach_item stim_items[$];
    t_speed     speed_expected[$];

    int sent_cnt      = 0;
    int taken_cnt     = 0;
    int results_seen  = 0;
    int fail_cnt      = 0;
    int send_gap      = 0;
    int stall_left    = 0;
    int next_stall_at = 30;
    int gen_items     = 0;
    bit fast_mode     = 1'b0;

    // model of the tachometer state
    logic [SPR_W-1:0]   m_spr;
    logic               m_seen;
    logic [COUNT_W-1:0] m_count;
    logic [TIME_W-1:0]  m_last;

    // generator mirror, used to aim read timestamps at chosen intervals
    logic               gen_seen = 1'b0;
    logic [TIME_W-1:0]  gen_last = '0;

    function automatic int pick_gap();
        int r;
        if (fast_mode)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic predict_speed(input t_tach_item item);
        logic [TIME_W-1:0] dt32;
        longint unsigned   dt;
        longint unsigned   div;
        longint unsigned   speed;
        t_speed            res;
        if (item.op == OP_PULSE) begin
            m_seen = 1'b1;
            if (m_count != '1)
                m_count = m_count + 1'b1;
        end else if (!m_seen) begin
            res = '0;
            speed_expected.push_back(res);
        end else begin
            dt32 = item.stamp - m_last;
            dt   = dt32;
            div  = (m_spr == '0) ? 64'd1 : m_spr;
            res.sat = 1'b0;
            if (dt == 0) begin
                res.rpm = RPM_MAX;
                res.sat = 1'b1;
            end else begin
                speed = (MINUTE_US / dt) * m_count / div;
                if (speed > RPM_LIMIT) begin
                    res.rpm = RPM_MAX;
                    res.sat = 1'b1;
                end else begin
                    res.rpm = speed[RPM_W-1:0];
                end
            end
            m_seen  = 1'b0;
            m_count = '0;
            m_last  = item.stamp;
            speed_expected.push_back(res);
        end
    endtask

    // monitor: predict on input transactions, check output transactions
    always @(posedge i_clk) begin : monitor
        t_tach_item seen_item;
        t_speed     want;
        if (!i_rst_n) begin
            m_spr   = SPR_RESET;
            m_seen  = 1'b0;
            m_count = '0;
            m_last  = '0;
        end else begin
            if (i_cfg_we)
                m_spr = i_cfg_wdata;
            if (i_valid && o_ready) begin
                seen_item.op    = i_opcode;
                seen_item.stamp = i_time_us;
                predict_speed(seen_item);
                taken_cnt++;
            end
            if (o_valid && i_ready) begin
                results_seen++;
                if (speed_expected.size() == 0) begin
                    $error("unexpected result: rpm %0d saturated %0d", o_rpm, o_saturated);
                    fail_cnt++;
                end else begin
                    want = speed_expected.pop_front();
                    if (o_rpm !== want.rpm) begin
                        $error("rpm mismatch: expected %0d, actual %0d", want.rpm, o_rpm);
                        fail_cnt++;
                    end
                    if (o_saturated !== want.sat) begin
                        $error("saturated mismatch: expected %0d, actual %0d",
                               want.sat, o_saturated);
                        fail_cnt++;
                    end
                end
            end
        end
    end

    // driver: hold the payload until the transaction is taken
    always @(negedge i_clk) begin : driver
        t_tach_item item;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (sent_cnt == taken_cnt) begin
            if (send_gap > 0) begin
                send_gap--;
                i_valid <= 1'b0;
            end else if (stim_items.size() > 0) begin
                item = stim_items.pop_front();
                i_opcode  <= item.op;
                i_time_us <= item.stamp;
                i_valid   <= 1'b1;
                sent_cnt++;
                send_gap = pick_gap();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus an occasional long hold-off
    always @(negedge i_clk) begin : receiver
        int g;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else if (results_seen >= next_stall_at) begin
            next_stall_at += 700;
            stall_left = HOLD_CYCLES - 1;
            i_ready <= 1'b0;
        end else begin
            g = pick_gap();
            if (g == 0) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= 1'b0;
                stall_left = g - 1;
            end
        end
    end

    task automatic queue_pulse(input logic [TIME_W-1:0] t);
        stim_items.push_back(t_tach_item'{OP_PULSE, t});
        gen_seen = 1'b1;
        gen_items++;
    endtask

    task automatic queue_read(input logic [TIME_W-1:0] t);
        stim_items.push_back(t_tach_item'{OP_READ, t});
        if (gen_seen)
            gen_last = t;
        gen_seen = 1'b0;
        gen_items++;
    endtask

    function automatic logic [TIME_W-1:0] pick_interval();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return '0;
        if (r < 25)
            return $urandom_range(1, 1000);
        if (r < 70)
            return $urandom_range(900, 200000);
        if (r < 85)
            return $urandom_range(200000, 60000001);
        return $urandom;
    endfunction

    task automatic queue_random_burst();
        int r;
        int k;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            queue_pulse($urandom);
        end else if (r < 15) begin
            queue_read($urandom);
        end else begin
            r = $urandom_range(0, 99);
            if (r < 70)
                k = $urandom_range(1, 8);
            else if (r < 98)
                k = $urandom_range(9, 40);
            else
                k = $urandom_range(200, 300);
            repeat (k) queue_pulse($urandom);
            queue_read(gen_last + pick_interval());
        end
    endtask

    task automatic write_sparks(input logic [SPR_W-1:0] v);
        @(negedge i_clk);
        i_cfg_wdata <= v;
        i_cfg_we    <= 1'b1;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic wait_drained();
        while (stim_items.size() != 0 || sent_cnt != taken_cnt || speed_expected.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        logic [SPR_W-1:0] sparks_plan[8];
        int               target;
        sparks_plan = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd2, 4'd3, 4'd5, 4'd7};
        sparks_plan[5] = SPR_W'($urandom_range(0, 15));
        sparks_plan[6] = SPR_W'($urandom_range(0, 15));

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // read before any pulse answers zero and keeps the stored time
        queue_read(32'd100);
        // zero interval
        queue_pulse('0);
        queue_read('0);
        // tiny interval clamps
        queue_pulse('1);
        queue_read(32'd1);
        queue_pulse('0);
        queue_pulse('0);
        queue_read(32'd20001);
        queue_read(32'd5);
        queue_pulse('1);
        queue_read('1);
        // timestamp wraps around
        queue_pulse('0);
        queue_read(32'h10);
        queue_pulse('0);
        queue_read(gen_last + 32'd60000000);
        queue_pulse('0);
        queue_read(gen_last + 32'd60000001);
        queue_pulse('0);
        queue_read(gen_last + 32'd916);
        queue_pulse(32'h5555_5555);
        queue_pulse(32'hAAAA_AAAA);
        queue_pulse('0);
        queue_read(gen_last + 32'd1831);
        // pulse count runs into its ceiling
        repeat (300) queue_pulse($urandom);
        queue_read(gen_last + 32'd1000000);
        wait_drained();

        for (int p = 0; p < 8; p++) begin
            write_sparks(sparks_plan[p]);
            fast_mode = (p % 3 == 2);
            target = gen_items + PHASE_ITEMS;
            while (gen_items < target)
                queue_random_burst();
            wait_drained();
        end

        if (fail_cnt == 0 && speed_expected.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin : watchdog
        #(30_000_000);
        $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
